// File: src/stc_pkg.sv
// Shared types and constants for the threshold spot centroid tracker.
// Holds the pixel, result, frame record and configuration structs, the register index and the state encodings.
// Depends on nothing.
package stc_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int CNT_W      = 21;
  localparam int SUM_W      = 31;
  localparam int LIM_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 21;

  // Gray weights, rounding term and scale (fixed point, 14 fraction bits).
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WB  = GRAY_SUM_W'(1868);
  localparam logic [GRAY_SUM_W-1:0] GRAY_WG  = GRAY_SUM_W'(9617);
  localparam logic [GRAY_SUM_W-1:0] GRAY_WR  = GRAY_SUM_W'(4899);
  localparam logic [GRAY_SUM_W-1:0] GRAY_RND = GRAY_SUM_W'(8192);

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_FQ_DEPTH = 2;

  localparam logic [PIX_W-1:0] RST_THRESH_LOW  = PIX_W'(200);
  localparam logic [PIX_W-1:0] RST_THRESH_HIGH = PIX_W'(255);
  localparam logic [CNT_W-1:0] RST_AREA_MIN    = CNT_W'(1);
  localparam logic [CNT_W-1:0] RST_AREA_MAX    = CNT_W'(39);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH_LOW  = 4'd0,
    CFG_THRESH_HIGH = 4'd1,
    CFG_AREA_MIN    = 4'd2,
    CFG_AREA_MAX    = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_X,
    BK_DIV_Y,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic               spot_found;
    logic [COORD_W-1:0] spot_x;
    logic [COORD_W-1:0] spot_y;
    logic               spot_still;
    logic [CNT_W-1:0]   lit_count;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_col;
    logic [SUM_W-1:0] sum_row;
  } frame_t;

  typedef struct packed {
    logic [PIX_W-1:0] thresh_low;
    logic [PIX_W-1:0] thresh_high;
    logic [CNT_W-1:0] area_min;
    logic [CNT_W-1:0] area_max;
  } cfg_t;

endpackage

// File: src/stc_front.sv
// Front end: gray conversion, threshold and per-frame moment accumulation.
// Pushes one frame record per frame into the frame queue. Uses stc_pkg.
module stc_front #(
  parameter int MAX_COLS = stc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = stc_pkg::DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  stc_pkg::cfg_t     cfg,
  input  stc_pkg::pixel_t   pixel,
  input  logic              push,
  output logic              full,
  output logic              fq_push,
  output stc_pkg::frame_t   fq_data,
  input  logic              fq_full
);

  logic [stc_pkg::GRAY_SUM_W-1:0] gray_sum;
  logic                           in_frame;

  logic                        a_valid;
  logic [stc_pkg::PIX_W-1:0]   a_gray;
  logic [stc_pkg::COORD_W-1:0] a_col;
  logic [stc_pkg::COORD_W-1:0] a_row;
  logic                        a_inside;
  logic                        a_fend;

  logic [stc_pkg::CNT_W-1:0] count_acc;
  logic [stc_pkg::SUM_W-1:0] sum_col_acc;
  logic [stc_pkg::SUM_W-1:0] sum_row_acc;

  logic                      lit;
  logic                      stall;
  logic [stc_pkg::CNT_W:0]   count_inc;
  logic [stc_pkg::SUM_W:0]   col_inc;
  logic [stc_pkg::SUM_W:0]   row_inc;
  logic [stc_pkg::CNT_W-1:0] count_next;
  logic [stc_pkg::SUM_W-1:0] sum_col_next;
  logic [stc_pkg::SUM_W-1:0] sum_row_next;

  assign gray_sum = stc_pkg::GRAY_SUM_W'(pixel.blue)  * stc_pkg::GRAY_WB
                  + stc_pkg::GRAY_SUM_W'(pixel.green) * stc_pkg::GRAY_WG
                  + stc_pkg::GRAY_SUM_W'(pixel.red)   * stc_pkg::GRAY_WR
                  + stc_pkg::GRAY_RND;

  assign in_frame =
    (stc_pkg::LIM_W'(pixel.col) < stc_pkg::LIM_W'(MAX_COLS)) &&
    (stc_pkg::LIM_W'(pixel.row) < stc_pkg::LIM_W'(MAX_ROWS));

  // Hold the last pixel of a frame while the frame queue has no room.
  assign stall = a_valid && a_fend && fq_full;
  assign full  = stall;

  assign lit = a_inside && (a_gray >= cfg.thresh_low) && (a_gray <= cfg.thresh_high);

  assign count_inc = {1'b0, count_acc} + (stc_pkg::CNT_W + 1)'(1);
  assign col_inc   = {1'b0, sum_col_acc} + (stc_pkg::SUM_W + 1)'(a_col);
  assign row_inc   = {1'b0, sum_row_acc} + (stc_pkg::SUM_W + 1)'(a_row);

  always_comb begin
    count_next   = count_acc;
    sum_col_next = sum_col_acc;
    sum_row_next = sum_row_acc;
    if (lit) begin
      count_next   = count_inc[stc_pkg::CNT_W] ? '1 : count_inc[stc_pkg::CNT_W-1:0];
      sum_col_next = col_inc[stc_pkg::SUM_W] ? '1 : col_inc[stc_pkg::SUM_W-1:0];
      sum_row_next = row_inc[stc_pkg::SUM_W] ? '1 : row_inc[stc_pkg::SUM_W-1:0];
    end
  end

  assign fq_push         = a_valid && a_fend && !fq_full;
  assign fq_data.count   = count_next;
  assign fq_data.sum_col = sum_col_next;
  assign fq_data.sum_row = sum_row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      count_acc   <= '0;
      sum_col_acc <= '0;
      sum_row_acc <= '0;
    end else if (!stall) begin
      a_valid <= push;
      if (a_valid) begin
        if (a_fend) begin
          count_acc   <= '0;
          sum_col_acc <= '0;
          sum_row_acc <= '0;
        end else begin
          count_acc   <= count_next;
          sum_col_acc <= sum_col_next;
          sum_row_acc <= sum_row_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && push) begin
      a_gray   <= gray_sum[stc_pkg::GRAY_SHIFT +: stc_pkg::PIX_W];
      a_col    <= pixel.col;
      a_row    <= pixel.row;
      a_inside <= in_frame;
      a_fend   <= pixel.frame_end;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fq_push |-> !fq_full)
    else $error("frame record pushed into a full queue");

endmodule

// File: src/stc_fifo.sv
// Short register queue of frame records between front and back end.
// Depth is a parameter, at least two. Uses stc_pkg for the record type.
module stc_fifo #(
  parameter int DEPTH = stc_pkg::DEF_FQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stc_pkg::frame_t din,
  output logic            full,
  input  logic            pop,
  output stc_pkg::frame_t dout,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  stc_pkg::frame_t entries [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= din;
    end
  end

endmodule

// File: src/stc_div.sv
// Restoring divider, one quotient bit per cycle, for the centroid.
// Divides a moment sum by the lit count. Uses stc_pkg widths.
module stc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [stc_pkg::SUM_W-1:0] dividend,
  input  logic [stc_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [stc_pkg::SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(stc_pkg::SUM_W);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [stc_pkg::CNT_W-1:0] rem;
  logic [stc_pkg::SUM_W-1:0] quo;
  logic [stc_pkg::CNT_W-1:0] dsr;
  logic [stc_pkg::CNT_W:0]   trial;
  logic [stc_pkg::CNT_W:0]   diff;
  logic                      fits;

  assign trial    = {rem, quo[stc_pkg::SUM_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = (trial >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(stc_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend through, subtract where the divisor fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[stc_pkg::CNT_W-1:0] : trial[stc_pkg::CNT_W-1:0];
      quo <= {quo[stc_pkg::SUM_W-2:0], fits};
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a division in flight");

endmodule

// File: src/stc_back.sv
// Back end: area window check, centroid division and still-spot detection.
// Takes frame records from the queue and holds one result. Uses stc_pkg, stc_div.
module stc_back (
  input  logic              clk,
  input  logic              rst,
  input  stc_pkg::cfg_t     cfg,
  input  stc_pkg::frame_t   fq_data,
  input  logic              fq_empty,
  output logic              fq_pop,
  output stc_pkg::result_t  result,
  output logic              empty,
  input  logic              pop
);

  stc_pkg::back_state_e state;
  stc_pkg::back_state_e state_next;

  stc_pkg::frame_t             rec;
  logic                        found_r;
  logic [stc_pkg::COORD_W-1:0] x_r;
  logic [stc_pkg::COORD_W-1:0] y_r;
  logic                        prev_valid;
  logic [stc_pkg::COORD_W-1:0] prev_x;
  logic [stc_pkg::COORD_W-1:0] prev_y;
  logic                        out_valid;
  stc_pkg::result_t            out_r;

  logic                        head_found;
  logic                        div_start;
  logic [stc_pkg::SUM_W-1:0]   div_dividend;
  logic [stc_pkg::CNT_W-1:0]   div_divisor;
  logic                        div_done;
  logic [stc_pkg::SUM_W-1:0]   div_quo;
  logic [stc_pkg::COORD_W-1:0] quo_clamped;
  logic                        ld_rec;
  logic                        ld_zero;
  logic                        ld_x;
  logic                        ld_y;
  logic                        wr_out;
  logic                        still;

  assign head_found = (fq_data.count >= cfg.area_min) && (fq_data.count <= cfg.area_max);
  assign quo_clamped = (|div_quo[stc_pkg::SUM_W-1:stc_pkg::COORD_W]) ? '1
                     : div_quo[stc_pkg::COORD_W-1:0];
  assign still = found_r && prev_valid && (x_r == prev_x) && (y_r == prev_y);

  stc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    fq_pop       = 1'b0;
    div_start    = 1'b0;
    div_dividend = rec.sum_row;
    div_divisor  = rec.count;
    ld_rec       = 1'b0;
    ld_zero      = 1'b0;
    ld_x         = 1'b0;
    ld_y         = 1'b0;
    wr_out       = 1'b0;
    case (state)
      stc_pkg::BK_IDLE: begin
        if (!fq_empty) begin
          fq_pop = 1'b1;
          ld_rec = 1'b1;
          if (head_found && (fq_data.count != '0)) begin
            div_start    = 1'b1;
            div_dividend = fq_data.sum_col;
            div_divisor  = fq_data.count;
            state_next   = stc_pkg::BK_DIV_X;
          end else begin
            ld_zero    = 1'b1;
            state_next = stc_pkg::BK_DONE;
          end
        end
      end
      stc_pkg::BK_DIV_X: begin
        if (div_done) begin
          ld_x       = 1'b1;
          div_start  = 1'b1;
          state_next = stc_pkg::BK_DIV_Y;
        end
      end
      stc_pkg::BK_DIV_Y: begin
        if (div_done) begin
          ld_y       = 1'b1;
          state_next = stc_pkg::BK_DONE;
        end
      end
      stc_pkg::BK_DONE: begin
        if (!out_valid || pop) begin
          wr_out     = 1'b1;
          state_next = stc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = stc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_rec) begin
      rec     <= fq_data;
      found_r <= head_found;
    end
    if (ld_zero) begin
      x_r <= '0;
      y_r <= '0;
    end
    if (ld_x) begin
      x_r <= quo_clamped;
    end
    if (ld_y) begin
      y_r <= quo_clamped;
    end
    if (wr_out) begin
      out_r.spot_found <= found_r;
      out_r.spot_x     <= x_r;
      out_r.spot_y     <= y_r;
      out_r.spot_still <= still;
      out_r.lit_count  <= rec.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_valid <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
    end else begin
      if (wr_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (wr_out && found_r) begin
        prev_valid <= 1'b1;
        prev_x     <= x_r;
        prev_y     <= y_r;
      end
    end
  end

  assign result = out_r;
  assign empty  = !out_valid;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == stc_pkg::BK_DIV_X) |-> (rec.count != '0))
    else $error("centroid division started with a zero count");

  a_still_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_r.spot_still) |-> out_r.spot_found)
    else $error("still flag on a frame without a spot");

  a_no_spot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_r.spot_found) |-> (out_r.spot_x == '0 && out_r.spot_y == '0))
    else $error("centroid not zero on a frame without a spot");

endmodule

// File: src/threshold_spot_centroid_tracker_core.sv
// Threshold spot centroid tracker, top level.
// Holds the configuration registers and ties front end, frame queue and back end.
// Uses stc_pkg, stc_front, stc_fifo, stc_back.
//
// The core takes one BGR pixel per clock, converts it to gray, marks it lit
// when it lies inside the inclusive threshold window, and sums the lit count
// and the lit columns and rows over a frame. On the pixel flagged frame_end
// it hands one frame record to a queue of FQ_DEPTH entries and starts the
// next frame in the following cycle, so pixels flow at one per clock. A back
// end takes each record, checks the count against the area window and, for a
// count inside it that is not zero, runs a shared one-bit-per-cycle restoring
// divider twice (column, then row). The result then waits in a one-entry
// output register. Pixel input stalls only while a last pixel waits in the
// front register for room in the frame queue (full goes high and holds the
// next pixel off), i.e. when short frames arrive faster than the back end
// retires them or results are not popped.
// Pixels with col >= MAX_COLS or row >= MAX_ROWS are never lit. Sums and the
// count saturate; a centroid above 1023 is clamped. The configuration port
// is always ready; write it only while no frame is in progress.
module threshold_spot_centroid_tracker_core #(
  parameter int MAX_COLS = stc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = stc_pkg::DEF_MAX_ROWS,
  parameter int FQ_DEPTH = stc_pkg::DEF_FQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel side
  input  logic                           push,
  output logic                           full,
  input  stc_pkg::pixel_t                pixel,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output stc_pkg::result_t               result,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data
);

  stc_pkg::cfg_t   cfg;
  logic            fq_push;
  stc_pkg::frame_t fq_din;
  logic            fq_full;
  logic            fq_pop;
  stc_pkg::frame_t fq_dout;
  logic            fq_empty;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh_low  <= stc_pkg::RST_THRESH_LOW;
      cfg.thresh_high <= stc_pkg::RST_THRESH_HIGH;
      cfg.area_min    <= stc_pkg::RST_AREA_MIN;
      cfg.area_max    <= stc_pkg::RST_AREA_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stc_pkg::CFG_THRESH_LOW:  cfg.thresh_low  <= cfg_data[stc_pkg::PIX_W-1:0];
        stc_pkg::CFG_THRESH_HIGH: cfg.thresh_high <= cfg_data[stc_pkg::PIX_W-1:0];
        stc_pkg::CFG_AREA_MIN:    cfg.area_min    <= cfg_data[stc_pkg::CNT_W-1:0];
        stc_pkg::CFG_AREA_MAX:    cfg.area_max    <= cfg_data[stc_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: convert, threshold, accumulate; one record per frame.
  stc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pixel   (pixel),
    .push    (push),
    .full    (full),
    .fq_push (fq_push),
    .fq_data (fq_din),
    .fq_full (fq_full)
  );

  // Frame queue: lets the divider run while the next frame streams in.
  stc_fifo #(
    .DEPTH (FQ_DEPTH)
  ) u_fq (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   (fq_din),
    .full  (fq_full),
    .pop   (fq_pop),
    .dout  (fq_dout),
    .empty (fq_empty)
  );

  // Back end: area window, centroid, still detection, result register.
  stc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fq_data  (fq_dout),
    .fq_empty (fq_empty),
    .fq_pop   (fq_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// File: dv/tb_top.sv
// Self-checking bench for threshold_spot_centroid_tracker_core: directed table, then random frames.
// Predicts each frame result from its own gray, threshold, moment and centroid logic, or uses the hand-written one.
// Depends on stc_pkg and the core RTL only.
module tb_top;
  import stc_pkg::*;

  // Gray weights in 14-bit fixed point, plus the rounding half.
  localparam int unsigned W_BLUE  = 1868;
  localparam int unsigned W_GREEN = 9617;
  localparam int unsigned W_RED   = 4899;
  localparam int unsigned W_ROUND = 8192;

  localparam int SETTLE_CYC  = 80;    // back end settle time after the last spot
  localparam int HANG_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 170;
  localparam logic [CNT_W-1:0] AREA_TOP = CNT_W'(1048576);

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    pixel_t                 pix;
    cfg_idx_e               idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;  // res holds a hand-written expectation
    result_t                res;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  pixel_t                pix = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               spot;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Hand-written expectation that travels with the pixel now on the bus.
  bit      typed_on = 1'b0;
  result_t typed_res = '0;
  bit      gaps_on = 1'b1;

  // Predictor state: registers, frame moments and the last found spot.
  cfg_t               model_cfg;
  frame_t             acc;
  bit                 prev_ok;
  logic [COORD_W-1:0] prev_x, prev_y;

  result_t spot_q[$];
  int      mismatches = 0;
  int      hang_cnt = 0;

  threshold_spot_centroid_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pix),
    .empty     (empty),
    .pop       (pop),
    .result    (spot),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] s, logic [COORD_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + v;
    return t[SUM_W] ? '1 : t[SUM_W-1:0];
  endfunction

  // Truncating divide; clamp anything past the last column or row.
  function automatic logic [COORD_W-1:0] centroid(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] q;
    if (cnt == '0) return '0;
    q = sum / SUM_W'(cnt);
    return (q > 1023) ? COORD_W'(1023) : q[COORD_W-1:0];
  endfunction

  // Fold one accepted pixel into the frame; on frame_end queue the expected spot.
  function automatic void track_pixel(pixel_t p, bit typed, result_t hand);
    int unsigned gray;
    bit          in_frame;
    result_t     r;
    gray = (W_BLUE * p.blue + W_GREEN * p.green + W_RED * p.red + W_ROUND) >> 14;
    in_frame = (p.col < DEF_MAX_COLS) && (p.row < DEF_MAX_ROWS);
    if (in_frame && gray >= model_cfg.thresh_low && gray <= model_cfg.thresh_high) begin
      acc.count   = (&acc.count) ? acc.count : acc.count + 1'b1;
      acc.sum_col = sat_sum(acc.sum_col, p.col);
      acc.sum_row = sat_sum(acc.sum_row, p.row);
    end
    if (!p.frame_end) return;
    r = '0;
    r.lit_count = acc.count;
    if (acc.count >= model_cfg.area_min && acc.count <= model_cfg.area_max) begin
      r.spot_found = 1'b1;
      r.spot_x     = centroid(acc.sum_col, acc.count);
      r.spot_y     = centroid(acc.sum_row, acc.count);
      r.spot_still = prev_ok && r.spot_x == prev_x && r.spot_y == prev_y;
      prev_ok = 1'b1;
      prev_x  = r.spot_x;
      prev_y  = r.spot_y;
    end
    acc = '0;
    spot_q.insert(spot_q.size(), typed ? hand : r);
  endfunction

  function automatic plan_row_t px(input logic [PIX_W-1:0] b, g, r,
                                   input logic [COORD_W-1:0] c, rw, input logic fe,
                                   input bit typed = 1'b0, input result_t res = '0);
    plan_row_t s;
    s.kind  = ROW_PIXEL;
    s.pix   = {b, g, r, c, rw, fe};
    s.idx   = CFG_THRESH_LOW;
    s.data  = '0;
    s.typed = typed;
    s.res   = res;
    return s;
  endfunction

  function automatic plan_row_t cf(cfg_idx_e idx, int unsigned val);
    plan_row_t s;
    s.kind  = ROW_CONFIG;
    s.pix   = '0;
    s.idx   = idx;
    s.data  = CFG_DATA_W'(val);
    s.typed = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  // Hold push high across back-to-back items; drop it only while idling.
  task automatic put_pixel(pixel_t p, bit typed, result_t res);
    cfg_valid <= 1'b0;
    if (gaps_on) begin
      while ($urandom_range(99) < 34) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push      <= 1'b1;
    pix       <= p;
    typed_on  <= typed;
    typed_res <= res;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Leave cfg_valid high so consecutive writes go out on consecutive cycles.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop sending, wait for every pending spot, then let the back end settle.
  task automatic drain();
    push      <= 1'b0;
    cfg_valid <= 1'b0;
    while (spot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Result side: stall about a third of the cycles unless gaps are off.
  always @(posedge clk) begin
    pop <= !rst && (!gaps_on || $urandom_range(99) >= 34);
  end

  // Sample all handshakes at the edge; check results before folding in a new pixel.
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (spot_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected spot: found=%0d x=%0d y=%0d still=%0d cnt=%0d",
                     spot.spot_found, spot.spot_x, spot.spot_y, spot.spot_still,
                     spot.lit_count);
        end else begin
          want = spot_q.pop_front();
          if (spot.spot_found !== want.spot_found || spot.spot_x !== want.spot_x ||
              spot.spot_y !== want.spot_y || spot.spot_still !== want.spot_still ||
              spot.lit_count !== want.lit_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("spot mismatch: exp found=%0d x=%0d y=%0d still=%0d cnt=%0d,",
                       want.spot_found, want.spot_x, want.spot_y, want.spot_still,
                       want.lit_count,
                       " got found=%0d x=%0d y=%0d still=%0d cnt=%0d",
                       spot.spot_found, spot.spot_x, spot.spot_y, spot.spot_still,
                       spot.lit_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_THRESH_LOW:  model_cfg.thresh_low  = cfg_data[PIX_W-1:0];
          CFG_THRESH_HIGH: model_cfg.thresh_high = cfg_data[PIX_W-1:0];
          CFG_AREA_MIN:    model_cfg.area_min    = cfg_data[CNT_W-1:0];
          CFG_AREA_MAX:    model_cfg.area_max    = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) track_pixel(pix, typed_on, typed_res);
    end
  end

  // Abort when no handshake of any kind has happened for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      hang_cnt <= 0;
    end else if (hang_cnt == HANG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin : stimulus
    plan_row_t        plan[$];
    pixel_t           frame_px[$];
    pixel_t           p;
    int               n_items;
    int               len;
    int               cx, cy;
    logic [PIX_W-1:0] lo, hi;
    logic [CNT_W-1:0] amin, amax;

    model_cfg = '{thresh_low: 8'd200, thresh_high: 8'd255, area_min: 21'd1, area_max: 21'd39};
    acc     = '0;
    prev_ok = 1'b0;
    prev_x  = '0;
    prev_y  = '0;

    // Directed table. Gray of pure blue, green, red at full scale is 29, 150, 76.
    plan = {
      px(0, 0, 0, 0, 0, 1, 1, result_t'{1'b0, 10'd0, 10'd0, 1'b0, 21'd0}),
      px(255, 255, 255, 1023, 1023, 1, 1, result_t'{1'b1, 10'd1023, 10'd1023, 1'b0, 21'd1}),
      px(255, 255, 255, 1023, 1023, 1, 1, result_t'{1'b1, 10'd1023, 10'd1023, 1'b1, 21'd1}),
      px(255, 255, 255, 0, 0, 0),
      px(255, 255, 255, 1, 3, 0),
      px(255, 255, 255, 2, 2, 1, 1, result_t'{1'b1, 10'd1, 10'd1, 1'b0, 21'd3}),
      // single-level threshold window
      cf(CFG_THRESH_LOW, 150),
      cf(CFG_THRESH_HIGH, 150),
      px(0, 255, 0, 5, 7, 1, 1, result_t'{1'b1, 10'd5, 10'd7, 1'b0, 21'd1}),
      px(255, 0, 0, 3, 4, 0),
      px(0, 0, 255, 9, 9, 1, 1, result_t'{1'b0, 10'd0, 10'd0, 1'b0, 21'd0}),
      px(1, 255, 1, 6, 6, 0),
      px(2, 255, 2, 8, 8, 1),
      // inverted thresholds: nothing lit
      cf(CFG_THRESH_LOW, 255),
      cf(CFG_THRESH_HIGH, 0),
      px(255, 255, 255, 100, 100, 1, 1, result_t'{1'b0, 10'd0, 10'd0, 1'b0, 21'd0}),
      // empty window allowed: zero count is a spot at the origin
      cf(CFG_AREA_MIN, 0),
      cf(CFG_AREA_MAX, 0),
      px(255, 255, 255, 100, 100, 1, 1, result_t'{1'b1, 10'd0, 10'd0, 1'b0, 21'd0}),
      px(0, 0, 0, 0, 0, 1, 1, result_t'{1'b1, 10'd0, 10'd0, 1'b1, 21'd0}),
      // inverted area window: lit but never found
      cf(CFG_THRESH_LOW, 0),
      cf(CFG_THRESH_HIGH, 255),
      cf(CFG_AREA_MIN, 5),
      cf(CFG_AREA_MAX, 4),
      px(17, 34, 51, 512, 256, 1, 1, result_t'{1'b0, 10'd0, 10'd0, 1'b0, 21'd1}),
      cf(CFG_AREA_MIN, 1048576),
      cf(CFG_AREA_MAX, 1048576),
      px(128, 128, 128, 1023, 0, 1, 1, result_t'{1'b0, 10'd0, 10'd0, 1'b0, 21'd1}),
      cf(CFG_AREA_MIN, 0),
      px(255, 255, 255, 1023, 1023, 0),
      px(0, 0, 0, 0, 0, 1)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        put_pixel(plan[i].pix, plan[i].typed, plan[i].res);
      end
    end

    // Random frames: clustered spots, some replayed to provoke still spots.
    for (int ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph != 3);
      drain();
      case (ph)
        0: begin
          lo   = PIX_W'($urandom_range(180, 220));
          hi   = 8'd255;
          amin = 21'd1;
          amax = CNT_W'($urandom_range(10, 40));
        end
        5: begin
          lo   = 8'd0;
          hi   = 8'd255;
          amin = 21'd0;
          amax = AREA_TOP;
        end
        7: begin
          lo   = 8'd255;
          hi   = 8'd255;
          amin = 21'd1;
          amax = AREA_TOP;
        end
        default: begin
          lo   = PIX_W'($urandom_range(0, 230));
          hi   = PIX_W'($urandom_range(lo, 255));
          amin = CNT_W'($urandom_range(0, 3));
          amax = CNT_W'($urandom_range(amin, 60));
          if ($urandom_range(5) == 0) {lo, hi} = {hi, lo};
        end
      endcase
      write_reg(CFG_THRESH_LOW, CFG_DATA_W'(lo));
      write_reg(CFG_THRESH_HIGH, CFG_DATA_W'(hi));
      write_reg(CFG_AREA_MIN, amin);
      write_reg(CFG_AREA_MAX, amax);

      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        if (frame_px.size() == 0 || $urandom_range(4) != 0) begin
          frame_px.delete();
          len = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
          cx  = $urandom_range(1023);
          cy  = $urandom_range(1023);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(4))
              0, 1: begin
                p.blue  = PIX_W'($urandom_range(180, 255));
                p.green = PIX_W'($urandom_range(180, 255));
                p.red   = PIX_W'($urandom_range(180, 255));
              end
              2: begin
                p.blue  = PIX_W'($urandom_range(255));
                p.green = PIX_W'($urandom_range(255));
                p.red   = PIX_W'($urandom_range(255));
              end
              3: begin
                p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(1) ? 8'hFF : 8'h00;
                p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
              end
              default: begin
                p.blue  = PIX_W'($urandom_range(60));
                p.green = PIX_W'($urandom_range(60));
                p.red   = PIX_W'($urandom_range(60));
              end
            endcase
            if ($urandom_range(4) == 0) begin
              p.col = COORD_W'($urandom_range(1023));
              p.row = COORD_W'($urandom_range(1023));
            end else begin
              p.col = COORD_W'(cx + $urandom_range(15));
              p.row = COORD_W'(cy + $urandom_range(15));
            end
            p.frame_end = (k == len - 1);
            frame_px.insert(frame_px.size(), p);
          end
        end
        foreach (frame_px[k]) put_pixel(frame_px[k], 1'b0, '0);
        n_items += frame_px.size();
      end
    end

    drain();
    if (mismatches == 0 && spot_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
